// File: rtl/all_pole_lattice_filter_core_macros.svh
// Assertion macros used by the lattice filter RTL.
`ifndef ALL_POLE_LATTICE_FILTER_CORE_MACROS_SVH
`define ALL_POLE_LATTICE_FILTER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define APL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define APL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/apl_pkg.sv
// Shared constants and types of the all-pole lattice filter.
package apl_pkg;

    // Default sizing
    localparam int MAX_ORDER_DEF    = 16;
    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int COEF_WIDTH_DEF   = 24;

    // Coefficients carry four integer bits, the rest is fraction
    localparam int COEF_INT_BITS = 4;

    // Request codes of an input transaction
    localparam logic REQ_FILTER = 1'b0;
    localparam logic REQ_LOAD   = 1'b1;

    // Register map: word addresses on the APB port
    localparam int APB_AW    = 3;
    localparam int REG_IDX_W = APB_AW - 2;
    localparam logic [REG_IDX_W-1:0] REG_ORDER = REG_IDX_W'(0);

    // Per-cycle controls of one state memory
    typedef struct packed {
        logic clr;
        logic we;
        logic re;
    } apl_mem_ctl_t;

endpackage

// File: rtl/all_pole_lattice_filter_core.sv
// All-pole lattice IIR filter: top level with APB register and state memories.
//
// Each request transaction is either a coefficient load or a sample. A sample
// fetches the gain, applies it (multiply, sum), then per lattice stage
// multiplies, subtracts, multiplies and writes back a delay, as a single
// registered multiplier serves both products of a stage in turn; a last step
// writes the first delay and registers the result. The result register lets
// the next transaction start while a result still waits on m_ready.
// Coefficients and delays live in two small synchronous memories; both read
// as zero until written, and writing the order register at word address 0
// (values above the maximum order saturate) clears the delays.
module all_pole_lattice_filter_core #(
    parameter int MAX_ORDER    = apl_pkg::MAX_ORDER_DEF,
    parameter int SAMPLE_WIDTH = apl_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = apl_pkg::COEF_WIDTH_DEF,
    parameter int IDX_W        = $clog2(MAX_ORDER + 1)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // APB register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [apl_pkg::APB_AW-1:0]     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // request channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_req_type,
    input  logic [IDX_W-1:0]               s_coef_index,
    input  logic signed [COEF_WIDTH-1:0]   s_coef_value,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample_in,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_sample_out
);

    localparam int DLY_AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

    logic [IDX_W-1:0]                 order_reg, order_next;
    logic                             order_wr;
    logic [apl_pkg::REG_IDX_W-1:0]    reg_idx;

    apl_pkg::apl_mem_ctl_t            coef_ctl;
    logic [IDX_W-1:0]                 coef_waddr;
    logic [COEF_WIDTH-1:0]            coef_wdata;
    logic [IDX_W-1:0]                 coef_raddr;
    logic [COEF_WIDTH-1:0]            coef_rdata;
    apl_pkg::apl_mem_ctl_t            dly_ctl;
    logic [DLY_AW-1:0]                dly_waddr;
    logic [SAMPLE_WIDTH-1:0]          dly_wdata;
    logic [DLY_AW-1:0]                dly_raddr;
    logic [SAMPLE_WIDTH-1:0]          dly_rdata;

    // Register decode
    assign pready   = 1'b1;
    assign reg_idx  = paddr[apl_pkg::APB_AW-1:2];
    assign order_wr = psel && penable && pwrite && (reg_idx == apl_pkg::REG_ORDER);

    // Order saturates to the depth of the lattice
    always_comb begin
        if (pwdata[IDX_W-1:0] > IDX_W'(MAX_ORDER)) begin
            order_next = IDX_W'(MAX_ORDER);
        end else begin
            order_next = pwdata[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= '0;
        end else if (order_wr) begin
            order_reg <= order_next;
        end
    end

    assign prdata = (reg_idx == apl_pkg::REG_ORDER) ? 32'(order_reg) : '0;

    // Sequencer and datapath
    apl_seq #(
        .MAX_ORDER    (MAX_ORDER),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH),
        .IDX_W        (IDX_W),
        .DLY_AW       (DLY_AW)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .order        (order_reg),
        .dly_clr      (order_wr),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_coef_index (s_coef_index),
        .s_coef_value (s_coef_value),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .coef_ctl     (coef_ctl),
        .coef_waddr   (coef_waddr),
        .coef_wdata   (coef_wdata),
        .coef_raddr   (coef_raddr),
        .coef_rdata   (coef_rdata),
        .dly_ctl      (dly_ctl),
        .dly_waddr    (dly_waddr),
        .dly_wdata    (dly_wdata),
        .dly_raddr    (dly_raddr),
        .dly_rdata    (dly_rdata)
    );

    // Gain and reflection coefficients
    apl_ram #(
        .DEPTH (MAX_ORDER + 1),
        .AW    (IDX_W),
        .DW    (COEF_WIDTH)
    ) u_coef_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (coef_ctl),
        .waddr   (coef_waddr),
        .wdata   (coef_wdata),
        .raddr   (coef_raddr),
        .rdata   (coef_rdata)
    );

    // Lattice delays
    apl_ram #(
        .DEPTH (MAX_ORDER),
        .AW    (DLY_AW),
        .DW    (SAMPLE_WIDTH)
    ) u_dly_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (dly_ctl),
        .waddr   (dly_waddr),
        .wdata   (dly_wdata),
        .raddr   (dly_raddr),
        .rdata   (dly_rdata)
    );

endmodule

// File: rtl/apl_ram.sv
// Single-write, single-read synchronous memory with per-entry valid bits.
module apl_ram #(
    parameter int DEPTH = apl_pkg::MAX_ORDER_DEF,
    parameter int AW    = 4,
    parameter int DW    = apl_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  apl_pkg::apl_mem_ctl_t ctl,
    input  logic [AW-1:0]         waddr,
    input  logic [DW-1:0]         wdata,
    input  logic [AW-1:0]         raddr,
    output logic [DW-1:0]         rdata
);

    logic [DW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [DW-1:0]    rdata_reg;

    // Valid bits: an entry never written reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctl.clr) begin
            valid_reg <= '0;
        end else if (ctl.we) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    // Storage array
    always_ff @(posedge aclk) begin
        if (ctl.we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge aclk) begin
        if (ctl.re) begin
            rdata_reg <= valid_reg[raddr] ? mem[raddr] : '0;
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/apl_seq.sv
// Stage sequencer and shared multiply datapath of the lattice filter.
`include "all_pole_lattice_filter_core_macros.svh"

module apl_seq #(
    parameter int MAX_ORDER    = apl_pkg::MAX_ORDER_DEF,
    parameter int SAMPLE_WIDTH = apl_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = apl_pkg::COEF_WIDTH_DEF,
    parameter int IDX_W        = 5,
    parameter int DLY_AW       = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [IDX_W-1:0]               order,
    input  logic                           dly_clr,
    // request channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_req_type,
    input  logic [IDX_W-1:0]               s_coef_index,
    input  logic signed [COEF_WIDTH-1:0]   s_coef_value,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample_in,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_sample_out,
    // coefficient memory
    output apl_pkg::apl_mem_ctl_t          coef_ctl,
    output logic [IDX_W-1:0]               coef_waddr,
    output logic [COEF_WIDTH-1:0]          coef_wdata,
    output logic [IDX_W-1:0]               coef_raddr,
    input  logic [COEF_WIDTH-1:0]          coef_rdata,
    // delay memory
    output apl_pkg::apl_mem_ctl_t          dly_ctl,
    output logic [DLY_AW-1:0]              dly_waddr,
    output logic [SAMPLE_WIDTH-1:0]        dly_wdata,
    output logic [DLY_AW-1:0]              dly_raddr,
    input  logic [SAMPLE_WIDTH-1:0]        dly_rdata
);

    localparam int FRAC = COEF_WIDTH - apl_pkg::COEF_INT_BITS;
    localparam int PW   = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int RW   = PW + 1 - FRAC;
    localparam int EW   = RW + 1;
    localparam logic [PW:0] RND_C = (PW + 1)'(1) << (FRAC - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_GMUL = 3'd1;
    localparam logic [2:0] ST_GSUM = 3'd2;
    localparam logic [2:0] ST_M1   = 3'd3;
    localparam logic [2:0] ST_S1   = 3'd4;
    localparam logic [2:0] ST_M2   = 3'd5;
    localparam logic [2:0] ST_WB   = 3'd6;
    localparam logic [2:0] ST_FIN  = 3'd7;

    logic [2:0]                     state_reg, state_next;
    logic [DLY_AW-1:0]              j_reg;
    logic                           first_reg;
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [SAMPLE_WIDTH-1:0] sum_reg;
    logic signed [COEF_WIDTH-1:0]   k_reg;
    logic signed [SAMPLE_WIDTH-1:0] d_reg;
    logic signed [PW-1:0]           p_reg;
    logic                           m_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_reg;

    logic                           accept;
    logic                           out_free;
    logic                           fin_fire;
    logic                           order_zero;
    logic                           j_zero;
    logic signed [COEF_WIDTH-1:0]   mul_a;
    logic signed [SAMPLE_WIDTH-1:0] mul_b;
    logic [PW:0]                    p_rnd;
    logic signed [RW-1:0]           rnd;
    logic signed [EW-1:0]           rnd_ext;
    logic signed [EW-1:0]           sum_diff;
    logic signed [EW-1:0]           dly_sum;

    // Clamp a widened value to the sample range
    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_f(input logic signed [EW-1:0] v);
        logic [EW-SAMPLE_WIDTH:0] upper;
        upper = v[EW-1:SAMPLE_WIDTH-1];
        if ((&upper) || !(|upper)) begin
            return v[SAMPLE_WIDTH-1:0];
        end else if (v[EW-1]) begin
            return {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
        end
    endfunction

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign fin_fire   = (state_reg == ST_FIN) && out_free;
    assign order_zero = (order == '0);
    assign j_zero     = (j_reg == '0);

    // Coefficient memory: loads from the request channel, reads per stage
    always_comb begin
        coef_ctl.clr = 1'b0;
        coef_ctl.we  = accept && (s_req_type == apl_pkg::REQ_LOAD)
                       && (s_coef_index <= IDX_W'(MAX_ORDER));
        coef_ctl.re  = (accept && (s_req_type == apl_pkg::REQ_FILTER))
                       || ((state_reg == ST_GSUM) && !order_zero)
                       || ((state_reg == ST_WB) && !j_zero);
        coef_waddr   = s_coef_index;
        coef_wdata   = s_coef_value;
        priority if (state_reg == ST_GSUM) begin
            coef_raddr = order;
        end else if (state_reg == ST_WB) begin
            coef_raddr = IDX_W'(j_reg);
        end else begin
            coef_raddr = '0;
        end
    end

    // Delay memory: next stage read, delay update write, final write of slot 0
    always_comb begin
        dly_ctl.clr = dly_clr;
        dly_ctl.re  = ((state_reg == ST_GSUM) && !order_zero)
                      || ((state_reg == ST_WB) && !j_zero);
        dly_ctl.we  = ((state_reg == ST_WB) && !first_reg)
                      || (fin_fire && !order_zero);
        if (state_reg == ST_GSUM) begin
            dly_raddr = DLY_AW'(order - IDX_W'(1));
        end else begin
            dly_raddr = j_reg - DLY_AW'(1);
        end
        if (state_reg == ST_WB) begin
            dly_waddr = j_reg + DLY_AW'(1);
            dly_wdata = sat_f(dly_sum);
        end else begin
            dly_waddr = '0;
            dly_wdata = sum_reg;
        end
    end

    // Shared multiplier operand select
    always_comb begin
        unique case (state_reg)
            ST_M1: begin
                mul_a = coef_rdata;
                mul_b = dly_rdata;
            end
            ST_M2: begin
                mul_a = k_reg;
                mul_b = sum_reg;
            end
            default: begin
                mul_a = coef_rdata;
                mul_b = x_reg;
            end
        endcase
    end

    // Round the product half up, then widen for the saturating sums
    assign p_rnd    = {p_reg[PW-1], p_reg} + RND_C;
    assign rnd      = p_rnd[PW:FRAC];
    assign rnd_ext  = EW'(rnd);
    assign sum_diff = EW'(sum_reg) - rnd_ext;
    assign dly_sum  = EW'(d_reg) + rnd_ext;

    // State sequencing
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_req_type == apl_pkg::REQ_FILTER)) begin
                    state_next = ST_GMUL;
                end
            end
            ST_GMUL: state_next = ST_GSUM;
            ST_GSUM: state_next = order_zero ? ST_FIN : ST_M1;
            ST_M1:   state_next = ST_S1;
            ST_S1:   state_next = ST_M2;
            ST_M2:   state_next = ST_WB;
            ST_WB:   state_next = j_zero ? ST_FIN : ST_M1;
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        p_reg <= mul_a * mul_b;
        if (accept) begin
            x_reg <= s_sample_in;
        end
        if (state_reg == ST_GSUM) begin
            sum_reg   <= sat_f(rnd_ext);
            j_reg     <= DLY_AW'(order - IDX_W'(1));
            first_reg <= 1'b1;
        end
        if (state_reg == ST_M1) begin
            k_reg <= coef_rdata;
            d_reg <= dly_rdata;
        end
        if (state_reg == ST_S1) begin
            sum_reg <= sat_f(sum_diff);
        end
        if ((state_reg == ST_WB) && !j_zero) begin
            j_reg     <= j_reg - DLY_AW'(1);
            first_reg <= 1'b0;
        end
        if (fin_fire) begin
            out_reg <= sum_reg;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fin_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = out_reg;

    // Checks
    `APL_ASSERT_NOW(a_dly_we_busy, aclk, aresetn, dly_ctl.we, state_reg != ST_IDLE,
        "delay write while idle")
    `APL_ASSERT_NOW(a_coef_we_load, aclk, aresetn, coef_ctl.we,
        accept && (s_req_type == apl_pkg::REQ_LOAD), "coefficient write without a load")
    `APL_ASSERT_NOW(a_top_stage_nowr, aclk, aresetn, (state_reg == ST_WB) && first_reg,
        !dly_ctl.we, "delay written past the top stage")
    `APL_ASSERT_NOW(a_dly_rd_range, aclk, aresetn, dly_ctl.re,
        32'(dly_raddr) < MAX_ORDER, "delay read beyond the store")
    `APL_ASSERT_NEXT(a_fin_result, aclk, aresetn, fin_fire,
        m_valid && (state_reg == ST_IDLE), "finished sample not presented")

endmodule

// File: dv/tb_all_pole_lattice_filter_core.sv
// Self-checking testbench for the all-pole lattice IIR filter core.
`timescale 1ns / 1ps

// Lattice filter predictor: own copy of the gain/reflection table, delays and order
class lattice_sb;
    localparam int MAX_ORD = 16;

    logic signed [23:0] coefs [MAX_ORD+1];
    logic signed [23:0] taps  [MAX_ORD];
    int unsigned        order;
    logic signed [23:0] expected_out [$];
    int unsigned        errors;
    int unsigned        samples_checked;
    int unsigned        loads_seen;
    int unsigned        order_writes;

    function new();
        foreach (coefs[i]) coefs[i] = '0;
        foreach (taps[i]) taps[i] = '0;
        order = 0;
        errors = 0;
        samples_checked = 0;
        loads_seen = 0;
        order_writes = 0;
    endfunction

    // Clamp to the 24-bit sample range
    function automatic longint clamp24(longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    // Q4.20 product, rounded half toward +inf
    function automatic longint qprod(longint c, longint x);
        longint p;
        p = c * x + (64'sd1 <<< 19);
        return p >>> 20;
    endfunction

    // Order register write: 5-bit field, saturating, clears the delays
    function void set_order(logic [31:0] value);
        int unsigned v;
        v = value[4:0];
        order = (v > MAX_ORD) ? MAX_ORD : v;
        foreach (taps[i]) taps[i] = '0;
        order_writes++;
    endfunction

    // Accepted request transaction: update the table or filter one sample
    function void note_request(logic rtype, logic [4:0] idx,
                               logic signed [23:0] cval, logic signed [23:0] xin);
        longint acc;
        int m;
        if (rtype == apl_pkg::REQ_LOAD) begin
            if (idx <= MAX_ORD) coefs[idx] = cval;
            loads_seen++;
            return;
        end
        acc = clamp24(qprod(coefs[0], xin));
        if (order > 0) begin
            acc = clamp24(acc - qprod(coefs[order], taps[order-1]));
            for (m = int'(order) - 2; m >= 0; m--) begin
                acc = clamp24(acc - qprod(coefs[m+1], taps[m]));
                taps[m+1] = 24'(clamp24(taps[m] + qprod(coefs[m+1], acc)));
            end
            taps[0] = 24'(acc);
        end
        expected_out.push_back(24'(acc));
    endfunction

    // Accepted result transaction against the oldest expectation
    function void check_output(logic signed [23:0] got);
        logic signed [23:0] want;
        if (expected_out.size() == 0) begin
            $display("%0t: unexpected sample_out %0d, nothing pending", $time, got);
            errors++;
            return;
        end
        want = expected_out.pop_front();
        samples_checked++;
        if (got !== want) begin
            $display("%0t: sample_out mismatch: expected %0d, actual %0d", $time, want, got);
            errors++;
        end
    endfunction
endclass

module tb_all_pole_lattice_filter_core;

    localparam int QUIET_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 80;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [apl_pkg::APB_AW-1:0] paddr = '0;
    logic [31:0]              pwdata = '0;
    logic [31:0]              prdata;
    logic                     pready;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic                     s_req_type = 1'b0;
    logic [4:0]               s_coef_index = '0;
    logic signed [23:0]       s_coef_value = '0;
    logic signed [23:0]       s_sample_in = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [23:0]       m_sample_out;

    lattice_sb   sb = new();
    bit          no_idle = 1'b0;
    int unsigned quiet_cycles = 0;

    all_pole_lattice_filter_core DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_coef_index (s_coef_index),
        .s_coef_value (s_coef_value),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= no_idle || ($urandom_range(99) >= 19);
    end

    // Monitor: results checked before a same-edge request is noted
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_output(m_sample_out);
            if (s_valid && s_ready)
                sb.note_request(s_req_type, s_coef_index, s_coef_value, s_sample_in);
            if ((m_valid && m_ready) || (s_valid && s_ready) || (psel && penable))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog
    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // One request transaction; valid stays up across back-to-back items
    task automatic send_request(input logic rtype, input logic [4:0] idx,
                                input logic signed [23:0] cval,
                                input logic signed [23:0] xin);
        if (!no_idle && $urandom_range(99) < 19) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= rtype;
        s_coef_index <= idx;
        s_coef_value <= cval;
        s_sample_in  <= xin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Unused fields carry random bits
    task automatic load_coef(input logic [4:0] idx, input logic signed [23:0] cval);
        send_request(apl_pkg::REQ_LOAD, idx, cval, 24'($urandom()));
    endtask

    task automatic filter_sample(input logic signed [23:0] xin);
        send_request(apl_pkg::REQ_FILTER, 5'($urandom()), 24'($urandom()), xin);
    endtask

    // Drop valid, let all results drain and the core fall idle
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_out.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // APB write of the order register: setup then access
    task automatic write_order(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= apl_pkg::APB_AW'(int'(apl_pkg::REG_ORDER) * 4);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_order(value);
    endtask

    // Mostly full-range samples, some small, some at the rails
    function automatic logic signed [23:0] rand_sample();
        case ($urandom_range(9))
            0:       return 24'sh7FFFFF;
            1:       return 24'sh800000;
            2, 3:    return 24'(int'($urandom_range(8192)) - 4096);
            default: return 24'($urandom());
        endcase
    endfunction

    // Reflection coefficient, mostly |k| < 0.94 for a stable lattice
    function automatic logic signed [23:0] rand_reflection();
        if ($urandom_range(9) == 0) return 24'($urandom());
        return 24'(int'($urandom_range(2 * 'hF0000)) - 'hF0000);
    endfunction

    // Gain between 0.25 and 2.0 either sign, occasionally anything
    function automatic logic signed [23:0] rand_gain();
        int g;
        if ($urandom_range(9) == 0) return 24'($urandom());
        g = int'($urandom_range('h40000, 'h200000));
        if ($urandom_range(3) == 0) g = -g;
        return 24'(g);
    endfunction

    // One frame: set order, load gain and k1..kN, then mixed traffic
    task automatic run_phase(input int unsigned ord_raw, input int unsigned n_items);
        int unsigned used;
        int unsigned roll;
        int unsigned slot;
        int          k;
        settle();
        write_order(ord_raw);
        used = (ord_raw[4:0] > 16) ? 16 : ord_raw[4:0];
        load_coef(5'd0, rand_gain());
        for (k = 1; k <= int'(used); k++) load_coef(5'(k), rand_reflection());
        for (k = 0; k < int'(n_items); k++) begin
            roll = $urandom_range(99);
            if (roll < 72) begin
                filter_sample(rand_sample());
            end else if (roll < 84) begin
                // per-frame update of a slot in use
                slot = $urandom_range(used);
                load_coef(5'(slot), (slot == 0) ? rand_gain() : rand_reflection());
            end else if (roll < 92) begin
                load_coef(5'($urandom_range(16)), rand_reflection());
            end else begin
                // slot beyond the table, must be ignored
                load_coef(5'($urandom_range(17, 31)), 24'($urandom()));
            end
        end
    endtask

    // Stimulus
    initial begin
        int p;
        int unsigned phase_orders [12];

        phase_orders = '{1, 16, 0, 31, 2, 8, 17, 5, 16, 3, 12, 0};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Order zero: gain only, rails and rounding
        write_order(32'd0);
        load_coef(5'd0, 24'sh100000);
        filter_sample(24'sh7FFFFF);
        filter_sample(24'sh800000);
        filter_sample(24'sd0);
        load_coef(5'd0, 24'sh7FFFFF);
        filter_sample(24'sh7FFFFF);
        filter_sample(24'sh800000);
        load_coef(5'd0, 24'sh800000);
        filter_sample(24'sh800000);
        load_coef(5'd31, 24'sh555555);
        filter_sample(24'sd1000);
        load_coef(5'd0, 24'sh080000);
        filter_sample(24'sd3);
        filter_sample(-24'sd3);

        // Order above the maximum saturates to 16; extreme k values
        settle();
        write_order(32'd31);
        load_coef(5'd0, 24'sh100000);
        load_coef(5'd16, 24'sh7FFFFF);
        load_coef(5'd1, 24'sh800000);
        filter_sample(24'sh7FFFFF);
        filter_sample(24'sh800000);
        filter_sample(24'sh7FFFFF);

        // Single stage impulse response with k1 = 0.75
        settle();
        write_order(32'd1);
        load_coef(5'd1, 24'sh0C0000);
        filter_sample(24'sd100000);
        filter_sample(24'sd0);
        filter_sample(24'sd0);

        // Random frames over a spread of orders, one with no idling at all
        for (p = 0; p < 12; p++) begin
            no_idle = (p == 4);
            run_phase(phase_orders[p], 95);
        end
        no_idle = 1'b0;

        settle();
        $display("Checked %0d filtered samples; %0d coefficient loads, %0d order writes",
                 sb.samples_checked, sb.loads_seen, sb.order_writes);
        $display("Orders 0 to 16 incl. saturated writes, rails, rounding and stale slots");
        if (sb.errors == 0 && sb.expected_out.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/apl_pkg.sv
rtl/apl_ram.sv
rtl/apl_seq.sv
rtl/all_pole_lattice_filter_core.sv
dv/tb_all_pole_lattice_filter_core.sv
